// File: rtl/core/lee_pkg.sv
package lee_pkg;

  // Word format of the point and the coefficients.
  localparam int unsigned VALUE_WIDTH   = 32;
  localparam int unsigned FRACTION_BITS = 16;
  localparam int unsigned COEF_WIDTH    = 31;
  localparam int unsigned CFG_IDX_WIDTH = 3;
  localparam int unsigned PC_WIDTH      = 4;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_SIGMA   = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_RHO     = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_BETA    = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_DT      = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_START_X = 3'd4;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_START_Y = 3'd5;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_START_Z = 3'd6;

  // Reset values, Q15.16.
  localparam logic [COEF_WIDTH-1:0]  SIGMA_RST = 31'd655360;
  localparam logic [COEF_WIDTH-1:0]  RHO_RST   = 31'd1835008;
  localparam logic [COEF_WIDTH-1:0]  BETA_RST  = 31'd174763;
  localparam logic [COEF_WIDTH-1:0]  DT_RST    = 31'd6554;
  localparam logic [VALUE_WIDTH-1:0] ONE_RST   = 32'd65536;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_SUB,
    OP_ADD,
    OP_MUL,
    OP_BRR,
    OP_LOAD
  } op_e;

  typedef enum logic [3:0] {
    SEL_X,
    SEL_Y,
    SEL_Z,
    SEL_SG,
    SEL_RH,
    SEL_BT,
    SEL_DT,
    SEL_T0,
    SEL_T1,
    SEL_DX,
    SEL_DY,
    SEL_DZ
  } sel_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT
  } state_e;

  typedef struct packed {
    op_e                 op;
    sel_e                src_a;
    sel_e                src_b;
    sel_e                dst;
    logic                last;
    logic [PC_WIDTH-1:0] target;
  } ctrl_word_t;

  localparam logic [PC_WIDTH-1:0] PC_LOAD = 4'd15;

  function automatic ctrl_word_t mk(op_e op, sel_e a, sel_e b, sel_e d, logic last,
                                    logic [PC_WIDTH-1:0] tgt);
    ctrl_word_t w;
    w.op     = op;
    w.src_a  = a;
    w.src_b  = b;
    w.dst    = d;
    w.last   = last;
    w.target = tgt;
    return w;
  endfunction

  // Microprogram for one Euler step, with the restart path at the end.
  function automatic ctrl_word_t rom_word(logic [PC_WIDTH-1:0] addr);
    ctrl_word_t w;
    unique case (addr)
      4'd0:  w = mk(OP_BRR,  SEL_X,  SEL_X,  SEL_X,  1'b0, PC_LOAD);
      4'd1:  w = mk(OP_SUB,  SEL_Y,  SEL_X,  SEL_T0, 1'b0, '0);
      4'd2:  w = mk(OP_MUL,  SEL_SG, SEL_T0, SEL_T0, 1'b0, '0);
      4'd3:  w = mk(OP_MUL,  SEL_DT, SEL_T0, SEL_DX, 1'b0, '0);
      4'd4:  w = mk(OP_SUB,  SEL_RH, SEL_Z,  SEL_T0, 1'b0, '0);
      4'd5:  w = mk(OP_MUL,  SEL_X,  SEL_T0, SEL_T0, 1'b0, '0);
      4'd6:  w = mk(OP_SUB,  SEL_T0, SEL_Y,  SEL_T0, 1'b0, '0);
      4'd7:  w = mk(OP_MUL,  SEL_DT, SEL_T0, SEL_DY, 1'b0, '0);
      4'd8:  w = mk(OP_MUL,  SEL_X,  SEL_Y,  SEL_T0, 1'b0, '0);
      4'd9:  w = mk(OP_MUL,  SEL_BT, SEL_Z,  SEL_T1, 1'b0, '0);
      4'd10: w = mk(OP_SUB,  SEL_T0, SEL_T1, SEL_T0, 1'b0, '0);
      4'd11: w = mk(OP_MUL,  SEL_DT, SEL_T0, SEL_DZ, 1'b0, '0);
      4'd12: w = mk(OP_ADD,  SEL_X,  SEL_DX, SEL_X,  1'b0, '0);
      4'd13: w = mk(OP_ADD,  SEL_Y,  SEL_DY, SEL_Y,  1'b0, '0);
      4'd14: w = mk(OP_ADD,  SEL_Z,  SEL_DZ, SEL_Z,  1'b1, '0);
      4'd15: w = mk(OP_LOAD, SEL_X,  SEL_X,  SEL_X,  1'b1, '0);
      default: w = mk(OP_NOP, SEL_X, SEL_X, SEL_X, 1'b1, '0);
    endcase
    return w;
  endfunction

endpackage

// File: rtl/core/lee_alu.sv
// Saturating fixed-point unit: add, subtract, and multiply with rounding to
// nearest (ties away from zero) at the binary point.
module lee_alu (
  input  lee_pkg::op_e                         op_i,
  input  logic signed [lee_pkg::VALUE_WIDTH-1:0] a_i,
  input  logic signed [lee_pkg::VALUE_WIDTH-1:0] b_i,
  output logic        [lee_pkg::VALUE_WIDTH-1:0] res_o,
  output logic                                   sat_o
);

  localparam int unsigned W  = lee_pkg::VALUE_WIDTH;
  localparam int unsigned F  = lee_pkg::FRACTION_BITS;
  localparam int unsigned RW = 2 * W - F;

  localparam logic [2*W-1:0] HALF    = (2 * W)'(1) << (F - 1);
  localparam logic [RW-1:0]  NEG_LIM = RW'(1) << (W - 1);
  localparam logic [RW-1:0]  POS_LIM = NEG_LIM - RW'(1);
  localparam logic [W-1:0]   W_MAX   = {1'b0, {(W - 1){1'b1}}};
  localparam logic [W-1:0]   W_MIN   = {1'b1, {(W - 1){1'b0}}};

  logic signed [2*W-1:0] prod;
  logic        [2*W-1:0] mag;
  logic        [2*W-1:0] rnd_full;
  logic        [RW-1:0]  rnd;
  logic                  neg;
  logic                  mul_ovf;
  logic        [W-1:0]   mul_res;
  logic        [W:0]     sum;
  logic                  sum_ovf;
  logic        [W-1:0]   sum_res;

  always_comb begin
    prod     = a_i * b_i;
    neg      = a_i[W-1] ^ b_i[W-1];
    mag      = neg ? (2 * W)'(-prod) : (2 * W)'(prod);
    rnd_full = mag + HALF;
    rnd      = rnd_full[2*W-1:F];
    mul_ovf  = neg ? (rnd > NEG_LIM) : (rnd > POS_LIM);
    if (mul_ovf) begin
      mul_res = neg ? W_MIN : W_MAX;
    end else begin
      mul_res = neg ? (W)'(-rnd[W-1:0]) : rnd[W-1:0];
    end

    if (op_i == lee_pkg::OP_SUB) begin
      sum = {a_i[W-1], a_i} - {b_i[W-1], b_i};
    end else begin
      sum = {a_i[W-1], a_i} + {b_i[W-1], b_i};
    end
    sum_ovf = sum[W] ^ sum[W-1];
    sum_res = sum_ovf ? (sum[W] ? W_MIN : W_MAX) : sum[W-1:0];

    unique case (op_i)
      lee_pkg::OP_MUL: begin
        res_o = mul_res;
        sat_o = mul_ovf;
      end
      lee_pkg::OP_ADD, lee_pkg::OP_SUB: begin
        res_o = sum_res;
        sat_o = sum_ovf;
      end
      default: begin
        res_o = '0;
        sat_o = 1'b0;
      end
    endcase
  end

endmodule

// File: rtl/core/lorenz_euler_step.sv
// Lorenz attractor point generator, forward Euler integration in signed Q15.16.
//
// Input stream: each request carries one flag in s_axis_tdata_i bit 0. A zero
// advances the held point by one Euler step; a one loads the configured start
// point. Every request yields exactly one result: the new x, y, z in
// m_axis_tdata_o and a saturation flag in m_axis_tuser_o.
//
// A microprogram in a read-only table drives one shared saturating
// add/subtract/multiply unit, one operation per cycle, and that unit sets the
// timing. An advance takes 15 microsteps and a restart 2; after the last
// microstep the sequencer loads the output register once it is free. One
// request is in work at a time and the next is taken the cycle after the
// output register loads.
//
// If the receiver stalls, the result is held in the output register, and a
// further finished result waits in the sequencer, blocking the input, until the
// register frees. Configuration writes are always taken and should only be
// issued while idle. Reset loads the default coefficients and the point
// (1, 1, 1), and empties the output register.
module lorenz_euler_step (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // Input stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [0] restart, [7:1] zero
  // Output stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [95:0] m_axis_tdata_o,   // [31:0] point_x, [63:32] point_y, [95:64] point_z
  output logic        m_axis_tuser_o    // [0] clamped
);

  localparam int unsigned W  = lee_pkg::VALUE_WIDTH;
  localparam int unsigned CW = lee_pkg::COEF_WIDTH;
  localparam int unsigned PW = lee_pkg::PC_WIDTH;

  // Configuration registers.
  logic [CW-1:0] sigma_q, rho_q, beta_q, dt_q;
  logic [W-1:0]  start_x_q, start_y_q, start_z_q;

  // Point and scratch registers of the datapath.
  logic [W-1:0] x_q, y_q, z_q, t0_q, t1_q, dx_q, dy_q, dz_q;

  // Sequencer.
  lee_pkg::state_e     state_q, state_d;
  logic [PW-1:0]       pc_q, pc_d;
  logic                restart_q;
  logic                sat_q, sat_d;
  lee_pkg::ctrl_word_t cw;

  // Output register.
  logic          out_valid_q;
  logic [3*W-1:0] out_data_q;
  logic          out_sat_q;
  logic          out_free;
  logic          out_load;

  logic          in_take;
  logic [W-1:0]  opa, opb, alu_res;
  logic          alu_sat;
  logic          wr_en;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == lee_pkg::ST_IDLE);
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_sat_q;

  assign cw = lee_pkg::rom_word(pc_q);

  function automatic logic [W-1:0] pick(lee_pkg::sel_e s, logic [W-1:0] x, logic [W-1:0] y,
                                        logic [W-1:0] z, logic [W-1:0] t0, logic [W-1:0] t1,
                                        logic [W-1:0] dx, logic [W-1:0] dy, logic [W-1:0] dz,
                                        logic [CW-1:0] sg, logic [CW-1:0] rh,
                                        logic [CW-1:0] bt, logic [CW-1:0] dt);
    logic [W-1:0] v;
    unique case (s)
      lee_pkg::SEL_X:  v = x;
      lee_pkg::SEL_Y:  v = y;
      lee_pkg::SEL_Z:  v = z;
      lee_pkg::SEL_SG: v = W'(sg);
      lee_pkg::SEL_RH: v = W'(rh);
      lee_pkg::SEL_BT: v = W'(bt);
      lee_pkg::SEL_DT: v = W'(dt);
      lee_pkg::SEL_T0: v = t0;
      lee_pkg::SEL_T1: v = t1;
      lee_pkg::SEL_DX: v = dx;
      lee_pkg::SEL_DY: v = dy;
      lee_pkg::SEL_DZ: v = dz;
      default:         v = '0;
    endcase
    return v;
  endfunction

  assign opa = pick(cw.src_a, x_q, y_q, z_q, t0_q, t1_q, dx_q, dy_q, dz_q,
                    sigma_q, rho_q, beta_q, dt_q);
  assign opb = pick(cw.src_b, x_q, y_q, z_q, t0_q, t1_q, dx_q, dy_q, dz_q,
                    sigma_q, rho_q, beta_q, dt_q);

  lee_alu u_alu (
    .op_i  (cw.op),
    .a_i   (opa),
    .b_i   (opb),
    .res_o (alu_res),
    .sat_o (alu_sat)
  );

  // Arithmetic microsteps write their destination register.
  assign wr_en = (state_q == lee_pkg::ST_RUN) &&
                 (cw.op == lee_pkg::OP_ADD || cw.op == lee_pkg::OP_SUB ||
                  cw.op == lee_pkg::OP_MUL);

  // Sequencer control.
  always_comb begin
    state_d  = state_q;
    pc_d     = pc_q;
    sat_d    = sat_q;
    out_load = 1'b0;
    unique case (state_q)
      lee_pkg::ST_IDLE: begin
        if (in_take) begin
          state_d = lee_pkg::ST_RUN;
          pc_d    = '0;
          sat_d   = 1'b0;
        end
      end
      lee_pkg::ST_RUN: begin
        sat_d = sat_q | (wr_en & alu_sat);
        if (cw.last) begin
          state_d = lee_pkg::ST_WAIT;
        end else if (cw.op == lee_pkg::OP_BRR && restart_q) begin
          pc_d = cw.target;
        end else begin
          pc_d = pc_q + PW'(1);
        end
      end
      lee_pkg::ST_WAIT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = lee_pkg::ST_IDLE;
        end
      end
      default: state_d = lee_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lee_pkg::ST_IDLE;
      pc_q      <= '0;
      sat_q     <= 1'b0;
      restart_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      sat_q   <= sat_d;
      if (in_take) begin
        restart_q <= s_axis_tdata_i[0];
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sigma_q   <= lee_pkg::SIGMA_RST;
      rho_q     <= lee_pkg::RHO_RST;
      beta_q    <= lee_pkg::BETA_RST;
      dt_q      <= lee_pkg::DT_RST;
      start_x_q <= lee_pkg::ONE_RST;
      start_y_q <= lee_pkg::ONE_RST;
      start_z_q <= lee_pkg::ONE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        lee_pkg::CFG_SIGMA:   sigma_q   <= cfg_data_i[CW-1:0];
        lee_pkg::CFG_RHO:     rho_q     <= cfg_data_i[CW-1:0];
        lee_pkg::CFG_BETA:    beta_q    <= cfg_data_i[CW-1:0];
        lee_pkg::CFG_DT:      dt_q      <= cfg_data_i[CW-1:0];
        lee_pkg::CFG_START_X: start_x_q <= cfg_data_i;
        lee_pkg::CFG_START_Y: start_y_q <= cfg_data_i;
        lee_pkg::CFG_START_Z: start_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Point state: reset to (1, 1, 1), loaded on restart, written by microsteps.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= lee_pkg::ONE_RST;
      y_q <= lee_pkg::ONE_RST;
      z_q <= lee_pkg::ONE_RST;
    end else if (state_q == lee_pkg::ST_RUN && cw.op == lee_pkg::OP_LOAD) begin
      x_q <= start_x_q;
      y_q <= start_y_q;
      z_q <= start_z_q;
    end else if (wr_en) begin
      if (cw.dst == lee_pkg::SEL_X) x_q <= alu_res;
      if (cw.dst == lee_pkg::SEL_Y) y_q <= alu_res;
      if (cw.dst == lee_pkg::SEL_Z) z_q <= alu_res;
    end
  end

  // Scratch registers carry no reset; each is written before it is read.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      if (cw.dst == lee_pkg::SEL_T0) t0_q <= alu_res;
      if (cw.dst == lee_pkg::SEL_T1) t1_q <= alu_res;
      if (cw.dst == lee_pkg::SEL_DX) dx_q <= alu_res;
      if (cw.dst == lee_pkg::SEL_DY) dy_q <= alu_res;
      if (cw.dst == lee_pkg::SEL_DZ) dz_q <= alu_res;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {z_q, y_q, x_q};
      out_sat_q  <= sat_q;
    end
  end

  // A request always starts the microprogram from its first step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> (state_q == lee_pkg::ST_RUN) && (pc_q == '0))
    else $error("request did not start the microprogram");

  // A new result enters the output register only from the waiting state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == lee_pkg::ST_WAIT))
    else $error("result appeared without a finished microprogram");

  // A restart never saturates, so its result must carry a clear flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && restart_q |=> !m_axis_tuser_o)
    else $error("restart result flagged as clamped");

  // Results are only handed over once the microprogram reached its last step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lee_pkg::ST_RUN) && !cw.last |=> !out_load)
    else $error("output loaded before the last microstep");

endmodule
